// ===== design/sgcw_pkg.sv =====
package sgcw_pkg;

    // Scale modes
    localparam logic [1:0] MODE_SMALL  = 2'd0;
    localparam logic [1:0] MODE_BIG    = 2'd1;
    localparam logic [1:0] MODE_MEDIUM = 2'd2;

    // Character codes that bound the font ranges
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_COLON   = 8'h3A;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    // Glyph slots in the font ROM
    localparam int         GLYPH_COUNT = 38;
    localparam logic [5:0] GLYPH_COLON = 6'd10;
    localparam logic [5:0] GLYPH_ALPHA = 6'd11;
    localparam logic [5:0] GLYPH_SPACE = 6'd37;

    // Pen advance, in columns
    localparam logic [3:0] ADV_GLYPH_SMALL = 4'd6;
    localparam logic [3:0] ADV_GLYPH_BIG   = 4'd11;
    localparam logic [3:0] ADV_SKIP_SMALL  = 4'd3;
    localparam logic [3:0] ADV_SKIP_BIG    = 4'd4;

    // Last column step of a glyph
    localparam logic [3:0] STEP_LAST_SMALL = 4'd4;
    localparam logic [3:0] STEP_LAST_BIG   = 4'd9;

    // Status of the shared pen adder
    typedef struct packed {
        logic in_range;  // column lies on the display
        logic at_edge;   // column is the rightmost display column
    } pen_stat_t;

    typedef struct packed {
        logic       known;
        logic [5:0] idx;
    } glyph_sel_t;

    // 5x7 font, one 7-bit column per entry, bit 0 is the top row
    localparam logic [6:0] GLYPH_ROM [GLYPH_COUNT][5] = '{
        '{7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E}, '{7'h00, 7'h42, 7'h7F, 7'h40, 7'h00},
        '{7'h42, 7'h61, 7'h51, 7'h49, 7'h46}, '{7'h21, 7'h41, 7'h45, 7'h4B, 7'h31},
        '{7'h18, 7'h14, 7'h12, 7'h7F, 7'h10}, '{7'h27, 7'h45, 7'h45, 7'h45, 7'h39},
        '{7'h3C, 7'h4A, 7'h49, 7'h49, 7'h30}, '{7'h01, 7'h71, 7'h09, 7'h05, 7'h03},
        '{7'h36, 7'h49, 7'h49, 7'h49, 7'h36}, '{7'h06, 7'h49, 7'h49, 7'h29, 7'h1E},
        '{7'h00, 7'h36, 7'h36, 7'h00, 7'h00},
        '{7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E}, '{7'h7F, 7'h49, 7'h49, 7'h49, 7'h36},
        '{7'h3E, 7'h41, 7'h41, 7'h41, 7'h22}, '{7'h7F, 7'h41, 7'h41, 7'h22, 7'h1C},
        '{7'h7F, 7'h49, 7'h49, 7'h49, 7'h41}, '{7'h7F, 7'h09, 7'h09, 7'h09, 7'h01},
        '{7'h3E, 7'h41, 7'h49, 7'h49, 7'h7A}, '{7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F},
        '{7'h00, 7'h41, 7'h7F, 7'h41, 7'h00}, '{7'h20, 7'h40, 7'h41, 7'h3F, 7'h01},
        '{7'h7F, 7'h08, 7'h14, 7'h22, 7'h41}, '{7'h7F, 7'h40, 7'h40, 7'h40, 7'h40},
        '{7'h7F, 7'h02, 7'h0C, 7'h02, 7'h7F}, '{7'h7F, 7'h04, 7'h08, 7'h10, 7'h7F},
        '{7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E}, '{7'h7F, 7'h09, 7'h09, 7'h09, 7'h06},
        '{7'h3E, 7'h41, 7'h51, 7'h21, 7'h5E}, '{7'h7F, 7'h09, 7'h19, 7'h29, 7'h46},
        '{7'h46, 7'h49, 7'h49, 7'h49, 7'h31}, '{7'h01, 7'h01, 7'h7F, 7'h01, 7'h01},
        '{7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F}, '{7'h1F, 7'h20, 7'h40, 7'h20, 7'h1F},
        '{7'h3F, 7'h40, 7'h38, 7'h40, 7'h3F}, '{7'h63, 7'h14, 7'h08, 7'h14, 7'h63},
        '{7'h07, 7'h08, 7'h70, 7'h08, 7'h07}, '{7'h61, 7'h51, 7'h49, 7'h45, 7'h43},
        '{7'h00, 7'h00, 7'h00, 7'h00, 7'h00}
    };

    // Map a character code to its font slot; letters fold case
    function automatic glyph_sel_t glyph_lookup(input logic [7:0] ch);
        glyph_sel_t sel;
        sel.known = 1'b1;
        sel.idx   = '0;
        if (ch >= CHAR_DIGIT_0 && ch <= CHAR_DIGIT_9) begin
            sel.idx = 6'(ch - CHAR_DIGIT_0);
        end else if (ch == CHAR_COLON) begin
            sel.idx = GLYPH_COLON;
        end else if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
            sel.idx = GLYPH_ALPHA + 6'(ch - CHAR_UPPER_A);
        end else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
            sel.idx = GLYPH_ALPHA + 6'(ch - CHAR_LOWER_A);
        end else if (ch == CHAR_SPACE) begin
            sel.idx = GLYPH_SPACE;
        end else begin
            sel.known = 1'b0;
        end
        return sel;
    endfunction

endpackage

// ===== design/sgcw_pen_alu.sv =====
// Shared pen adder: column address during drawing, saturated pen step at the end
module sgcw_pen_alu #(
    parameter int DISPLAY_WIDTH = 64
) (
    input  logic signed [15:0]  pen_i,
    input  logic [3:0]          offset_i,
    output logic [15:0]         pen_sat_o,
    output logic [5:0]          column_o,
    output sgcw_pkg::pen_stat_t stat_o
);

    localparam logic [16:0] WIDTH_LIM = 17'(DISPLAY_WIDTH);
    localparam logic [16:0] EDGE_COL  = 17'(DISPLAY_WIDTH - 1);

    logic [16:0] sum;

    assign sum = {pen_i[15], pen_i} + 17'(offset_i);

    // Offsets are never negative, so only the top end can overflow
    assign pen_sat_o = (!sum[16] && sum[15]) ? 16'h7FFF : sum[15:0];

    assign column_o        = sum[5:0];
    assign stat_o.in_range = !sum[16] && (sum < WIDTH_LIM);
    assign stat_o.at_edge  = (sum == EDGE_COL);

endmodule

// ===== design/sgcw_row_place.sv =====
// Spreads one 7-bit font column over display rows, with row doubling and clipping
module sgcw_row_place #(
    parameter int DISPLAY_HEIGHT = 32
) (
    input  logic [6:0]        bits_i,
    input  logic signed [6:0] top_i,
    input  logic              tall_i,
    output logic [31:0]       data_o,
    output logic [31:0]       en_o
);

    localparam int RowLimit = (DISPLAY_HEIGHT < 32) ? DISPLAY_HEIGHT : 32;

    logic [7:0] diff;
    logic [7:0] row_j;

    // Each display row picks its glyph row independently
    always_comb begin
        data_o = '0;
        en_o   = '0;
        diff   = '0;
        row_j  = '0;
        for (int r = 0; r < 32; r++) begin
            diff  = 8'(r) - {top_i[6], top_i};
            row_j = tall_i ? {diff[7], diff[7:1]} : diff;
            if (r < RowLimit && !row_j[7] && row_j < 8'd7) begin
                en_o[r]   = 1'b1;
                data_o[r] = bits_i[row_j[2:0]];
            end
        end
    end

endmodule

// ===== design/scaled_glyph_column_writer.sv =====
// Character generator that draws 5x7 font glyphs as framebuffer column writes.
// Each request carries one character; a request with s_tuser set first loads the
// pen column, top row and scale mode (small 5x7, big 10x14, medium 5x14). Every
// glyph column that lands on the display gives one result: the column address, a
// 32-bit row data word and its row enable mask, with m_tlast on the character's
// final write. Unknown characters give no result and step the pen by 3 (4 in big
// mode). A known character walks at most 5 or 10 column steps, one step per cycle
// through the single pen adder while m_tready does not hold the output register. A
// glyph with every row clipped stops after one step, and the right display edge
// ends the walk early. s_tready is high only between characters.
module scaled_glyph_column_writer #(
    parameter int DISPLAY_WIDTH  = 64,
    parameter int DISPLAY_HEIGHT = 32
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // char_code[7:0], start_column[19:8], top_row[26:20], scale_mode[28:27]
    input  logic [31:0] s_tdata,
    // starts_string[0]
    input  logic        s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // column[5:0], row_bits[37:6], row_enable[69:38]
    output logic [71:0] m_tdata,
    output logic        m_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DRAW = 3'b010,
        ST_ADV  = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic signed [15:0] pen_reg, pen_next;
    logic signed [6:0]  top_reg, top_next;
    logic [1:0]         mode_reg, mode_next;
    logic [5:0]         glyph_reg, glyph_next;
    logic               known_reg, known_next;
    logic [3:0]         step_reg, step_next;
    logic               ovalid_reg, ovalid_next;
    logic [5:0]         ocol_reg;
    logic [31:0]        obits_reg;
    logic [31:0]        oen_reg;
    logic               olast_reg;

    logic                big;
    logic                tall;
    logic [3:0]          step_last;
    logic [3:0]          adv;
    logic [3:0]          alu_offset;
    logic [15:0]         pen_sat;
    logic [5:0]          alu_col;
    sgcw_pkg::pen_stat_t alu_stat;
    logic [2:0]          font_col;
    logic [6:0]          font_bits;
    logic [31:0]         row_data;
    logic [31:0]         row_en;
    logic                s_fire;
    logic                slot_free;
    logic                load_out;
    logic                out_last;
    sgcw_pkg::glyph_sel_t in_sel;

    assign big  = (mode_reg == sgcw_pkg::MODE_BIG);
    assign tall = big || (mode_reg == sgcw_pkg::MODE_MEDIUM);

    assign step_last = big ? sgcw_pkg::STEP_LAST_BIG : sgcw_pkg::STEP_LAST_SMALL;

    // Pen advance once the character is done
    always_comb begin
        if (known_reg) begin
            adv = big ? sgcw_pkg::ADV_GLYPH_BIG : sgcw_pkg::ADV_GLYPH_SMALL;
        end else begin
            adv = big ? sgcw_pkg::ADV_SKIP_BIG : sgcw_pkg::ADV_SKIP_SMALL;
        end
    end

    assign alu_offset = (state_reg == ST_ADV) ? adv : step_reg;

    sgcw_pen_alu #(
        .DISPLAY_WIDTH(DISPLAY_WIDTH)
    ) u_pen_alu (
        .pen_i    (pen_reg),
        .offset_i (alu_offset),
        .pen_sat_o(pen_sat),
        .column_o (alu_col),
        .stat_o   (alu_stat)
    );

    // Font column under the current step; big mode doubles each column
    assign font_col  = big ? step_reg[3:1] : step_reg[2:0];
    assign font_bits = sgcw_pkg::GLYPH_ROM[glyph_reg][font_col];

    sgcw_row_place #(
        .DISPLAY_HEIGHT(DISPLAY_HEIGHT)
    ) u_row_place (
        .bits_i(font_bits),
        .top_i (top_reg),
        .tall_i(tall),
        .data_o(row_data),
        .en_o  (row_en)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign in_sel    = sgcw_pkg::glyph_lookup(s_tdata[7:0]);
    assign slot_free = !ovalid_reg || m_tready;
    assign out_last  = (step_reg == step_last) || alu_stat.at_edge;

    // Sequencer: accept, walk the glyph columns, step the pen
    always_comb begin
        state_next = state_reg;
        pen_next   = pen_reg;
        top_next   = top_reg;
        mode_next  = mode_reg;
        glyph_next = glyph_reg;
        known_next = known_reg;
        step_next  = step_reg;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_tuser) begin
                        pen_next  = {{4{s_tdata[19]}}, s_tdata[19:8]};
                        top_next  = s_tdata[26:20];
                        mode_next = s_tdata[28:27];
                    end
                    glyph_next = in_sel.idx;
                    known_next = in_sel.known;
                    step_next  = '0;
                    state_next = in_sel.known ? ST_DRAW : ST_ADV;
                end
            end
            ST_DRAW: begin
                if (row_en == '0) begin
                    // every row clipped: nothing to write
                    state_next = ST_ADV;
                end else if (!alu_stat.in_range) begin
                    if (step_reg == step_last) begin
                        state_next = ST_ADV;
                    end else begin
                        step_next = step_reg + 4'd1;
                    end
                end else if (slot_free) begin
                    load_out = 1'b1;
                    if (out_last) begin
                        state_next = ST_ADV;
                    end else begin
                        step_next = step_reg + 4'd1;
                    end
                end
            end
            ST_ADV: begin
                pen_next   = pen_sat;
                step_next  = '0;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register valid
    always_comb begin
        if (load_out) begin
            ovalid_next = 1'b1;
        end else if (m_tready) begin
            ovalid_next = 1'b0;
        end else begin
            ovalid_next = ovalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            pen_reg    <= '0;
            top_reg    <= '0;
            mode_reg   <= sgcw_pkg::MODE_SMALL;
            known_reg  <= 1'b0;
            step_reg   <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            pen_reg    <= pen_next;
            top_reg    <= top_next;
            mode_reg   <= mode_next;
            known_reg  <= known_next;
            step_reg   <= step_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        glyph_reg <= glyph_next;
        if (load_out) begin
            ocol_reg  <= alu_col;
            obits_reg <= row_data;
            oen_reg   <= row_en;
            olast_reg <= out_last;
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {2'b00, oen_reg, obits_reg, ocol_reg};
    assign m_tlast  = olast_reg;

endmodule

// ===== sim/scaled_glyph_column_writer_tb.sv =====
module scaled_glyph_column_writer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DISPLAY_WIDTH  = 64;
    localparam int DISPLAY_HEIGHT = 32;
    localparam int ROW_LIMIT      = (DISPLAY_HEIGHT < 32) ? DISPLAY_HEIGHT : 32;
    localparam int PEN_MAX        = 32767;
    localparam int PEN_MIN        = -32768;
    localparam int NO_GLYPH       = -1;
    localparam int RANDOM_CHARS   = 170;
    localparam int SATURATE_CHARS = 16;
    localparam int DRAIN_CYCLES   = 40;

    // Mode value with no name in the package; the block treats it as small
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // Font: one glyph per entry, column 0 in the top byte, bit 0 is the glyph's top row
    localparam logic [0:37][39:0] FONT = {
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000,
        40'h7E1111117E, 40'h7F49494936, 40'h3E41414122, 40'h7F4141221C,
        40'h7F49494941, 40'h7F09090901, 40'h3E4149497A, 40'h7F0808087F,
        40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
        40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906,
        40'h3E4151215E, 40'h7F09192946, 40'h4649494931, 40'h01017F0101,
        40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F, 40'h6314081463,
        40'h0708700807, 40'h6151494543, 40'h0000000000
    };

    typedef struct {
        logic [7:0]  char_code;
        logic        starts;
        logic [11:0] start_col;
        logic [6:0]  top;
        logic [1:0]  mode;
    } char_request_t;

    typedef struct {
        logic [5:0]  column;
        logic [31:0] row_bits;
        logic [31:0] row_enable;
        logic        last;
    } column_write_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        m_tlast;

    char_request_t char_requests[$];
    column_write_t writes_due[$];
    char_request_t in_flight;

    // Pen state as the block should hold it
    int         pen_col   = 0;
    int         top_held  = 0;
    logic [1:0] mode_held = sgcw_pkg::MODE_SMALL;

    int mismatch_count = 0;
    int chars_accepted = 0;
    int blank_chars    = 0;
    int writes_checked = 0;
    int drv_gap        = 0;
    int mon_stall      = 0;
    int mon_cycles     = 0;
    bit drv_idle_on    = 1'b1;
    bit mon_idle_on    = 1'b1;

    scaled_glyph_column_writer #(
        .DISPLAY_WIDTH (DISPLAY_WIDTH),
        .DISPLAY_HEIGHT(DISPLAY_HEIGHT)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Font slot of a character, letters case folded
    function automatic int font_slot(input logic [7:0] ch);
        if (ch >= "0" && ch <= "9") return int'(ch) - int'("0");
        if (ch == ":") return 10;
        if (ch >= "A" && ch <= "Z") return 11 + int'(ch) - int'("A");
        if (ch >= "a" && ch <= "z") return 11 + int'(ch) - int'("a");
        if (ch == " ") return 37;
        return NO_GLYPH;
    endfunction

    function automatic int pen_step(input int pen, input int delta);
        int sum;
        sum = pen + delta;
        if (sum > PEN_MAX) sum = PEN_MAX;
        if (sum < PEN_MIN) sum = PEN_MIN;
        return sum;
    endfunction

    // Column writes that one character request causes, in order; moves the pen
    function automatic void render_glyph(input char_request_t rq);
        int            idx;
        int            r;
        int            c;
        bit            big;
        bit            tall;
        logic [6:0]    font_col;
        logic [31:0]   bits;
        logic [31:0]   en;
        column_write_t w;
        column_write_t char_writes[$];
        if (rq.starts) begin
            pen_col   = $signed(rq.start_col);
            top_held  = $signed(rq.top);
            mode_held = rq.mode;
        end
        big  = (mode_held == sgcw_pkg::MODE_BIG);
        tall = big || (mode_held == sgcw_pkg::MODE_MEDIUM);
        idx  = font_slot(rq.char_code);

        // unknown character: skip ahead, nothing drawn
        if (idx == NO_GLYPH) begin
            pen_col = pen_step(pen_col, big ? 4 : 3);
            blank_chars++;
            return;
        end

        for (int i = 0; i < 5; i++) begin
            font_col = FONT[idx][8 * (4 - i) +: 7];
            bits     = '0;
            en       = '0;
            for (int j = 0; j < 7; j++) begin
                for (int d = 0; d < (tall ? 2 : 1); d++) begin
                    r = tall ? top_held + 2 * j + d : top_held + j;
                    if (r >= 0 && r < ROW_LIMIT) begin
                        en[r]   = 1'b1;
                        bits[r] = font_col[j];
                    end
                end
            end
            for (int k = 0; k < (big ? 2 : 1); k++) begin
                c = big ? pen_col + 2 * i + k : pen_col + i;
                if (c < 0 || c >= DISPLAY_WIDTH || en == '0) continue;
                w.column     = 6'(c);
                w.row_bits   = bits;
                w.row_enable = en;
                w.last       = 1'b0;
                char_writes.push_back(w);
            end
        end

        if (char_writes.size() == 0) blank_chars++;
        else char_writes[char_writes.size() - 1].last = 1'b1;
        foreach (char_writes[n]) writes_due.push_back(char_writes[n]);
        pen_col = pen_step(pen_col, big ? 11 : 6);
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap(input bit idle_on);
        int roll;
        if (!idle_on) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void queue_char(input logic [7:0] ch, input bit starts, input int col,
                                       input int top, input logic [1:0] mode);
        char_request_t rq;
        rq.char_code = ch;
        rq.starts    = starts;
        rq.start_col = 12'(col);
        rq.top       = 7'(top);
        rq.mode      = mode;
        char_requests.push_back(rq);
    endfunction

    function automatic logic [7:0] random_char();
        int pick;
        if ($urandom_range(0, 99) < 20) return 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 63);
        if (pick < 10) return 8'(int'("0") + pick);
        if (pick == 10) return ":";
        if (pick < 37) return 8'(int'("A") + pick - 11);
        if (pick < 63) return 8'(int'("a") + pick - 37);
        return " ";
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("[%0t] mismatch on %s: expected %h, got %h", $time, what, want, got);
        mismatch_count++;
    endtask

    // Stimulus
    initial begin
        int col;
        int top;
        int len;
        int random_sent;

        // directed: reset state, every glyph class, unknowns, clipping at each edge
        queue_char("A", 1'b0, 0, 0, sgcw_pkg::MODE_SMALL);
        queue_char("0", 1'b1, 0, 0, sgcw_pkg::MODE_SMALL);
        queue_char("9", 1'b0, 0, 0, sgcw_pkg::MODE_SMALL);
        queue_char(":", 1'b0, 0, 0, sgcw_pkg::MODE_SMALL);
        queue_char("Z", 1'b0, 0, 0, sgcw_pkg::MODE_SMALL);
        queue_char("z", 1'b0, 0, 0, sgcw_pkg::MODE_SMALL);
        queue_char("a", 1'b0, 0, 0, sgcw_pkg::MODE_SMALL);
        queue_char(" ", 1'b0, 0, 0, sgcw_pkg::MODE_SMALL);
        queue_char(8'h00, 1'b0, 0, 0, sgcw_pkg::MODE_SMALL);
        queue_char(8'hFF, 1'b0, 0, 0, sgcw_pkg::MODE_SMALL);
        queue_char("M", 1'b1, 50, 25, sgcw_pkg::MODE_BIG);
        queue_char("B", 1'b1, -3, -5, sgcw_pkg::MODE_MEDIUM);
        queue_char("H", 1'b1, -2048, -64, sgcw_pkg::MODE_SMALL);
        queue_char("8", 1'b1, 2047, 63, MODE_SPARE);
        queue_char("#", 1'b1, 60, 28, MODE_SPARE);
        queue_char("E", 1'b0, 0, 0, sgcw_pkg::MODE_SMALL);
        queue_char("W", 1'b1, 10, -13, sgcw_pkg::MODE_BIG);
        queue_char("1", 1'b1, 10, -14, sgcw_pkg::MODE_BIG);
        queue_char("Q", 1'b1, 0, 18, sgcw_pkg::MODE_MEDIUM);
        queue_char("?", 1'b1, 20, 2, sgcw_pkg::MODE_BIG);
        queue_char("K", 1'b0, 0, 0, sgcw_pkg::MODE_SMALL);
        queue_char("x", 1'b1, -4, 31, sgcw_pkg::MODE_SMALL);
        queue_char("5", 1'b1, 58, 0, sgcw_pkg::MODE_BIG);

        // pen far right of the display; a column that wrapped would land on it again
        queue_char("W", 1'b1, 2047, 0, sgcw_pkg::MODE_BIG);
        for (int n = 0; n < SATURATE_CHARS; n++) begin
            queue_char((n % 16 == 15) ? "%" : "W", 1'b0, $urandom_range(0, 4095),
                       $urandom_range(0, 127), 2'($urandom_range(0, 3)));
        end

        // random strings: a loading request followed by continuation characters
        random_sent = 0;
        while (random_sent < RANDOM_CHARS) begin
            len = $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 99) < 70) col = $urandom_range(0, 100) - 30;
                else col = $urandom_range(0, 4095);
                if ($urandom_range(0, 99) < 70) top = $urandom_range(0, 45) - 15;
                else top = $urandom_range(0, 127);
                queue_char(random_char(), k == 0, col, top, 2'($urandom_range(0, 3)));
                random_sent++;
            end
        end
    end

    // Request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                render_glyph(in_flight);
                chars_accepted++;
                if (chars_accepted % 40 == 0) drv_idle_on = ($urandom_range(0, 3) != 0);
                drv_gap = pick_gap(drv_idle_on);
            end
            // channel free: either idle or just accepted
            if (!s_tvalid || s_tready) begin
                if (drv_gap == 0 && char_requests.size() > 0) begin
                    in_flight = char_requests.pop_front();
                    s_tdata   <= {3'b000, in_flight.mode, in_flight.top,
                                  in_flight.start_col, in_flight.char_code};
                    s_tuser   <= in_flight.starts;
                    s_tvalid  <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                    if (drv_gap > 0) drv_gap--;
                end
            end
        end
    end

    // Column write monitor and checker
    always @(posedge aclk) begin
        column_write_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (writes_due.size() == 0) begin
                    report_mismatch("column write with nothing pending, column", 32'd0,
                                    32'(m_tdata[5:0]));
                end else begin
                    want = writes_due.pop_front();
                    writes_checked++;
                    if (m_tdata[5:0] !== want.column)
                        report_mismatch("column", 32'(want.column), 32'(m_tdata[5:0]));
                    if (m_tdata[37:6] !== want.row_bits)
                        report_mismatch("row_bits", want.row_bits, m_tdata[37:6]);
                    if (m_tdata[69:38] !== want.row_enable)
                        report_mismatch("row_enable", want.row_enable, m_tdata[69:38]);
                    if (m_tdata[71:70] !== 2'b00)
                        report_mismatch("tdata padding", 32'd0, 32'(m_tdata[71:70]));
                    if (m_tlast !== want.last)
                        report_mismatch("last_of_char", 32'(want.last), 32'(m_tlast));
                end
            end

            // back-pressure, switched off for some stretches
            mon_cycles++;
            if (mon_cycles % 64 == 0) mon_idle_on = ($urandom_range(0, 3) != 0);
            if (mon_stall > 0) begin
                m_tready <= 1'b0;
                mon_stall--;
            end else begin
                m_tready <= 1'b1;
                mon_stall = pick_gap(mon_idle_on);
            end
        end
    end

    // End of run
    initial begin
        wait (aresetn === 1'b1);
        do @(negedge aclk);
        while (char_requests.size() != 0 || s_tvalid || writes_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("%0d characters accepted (%0d without any write), %0d column writes checked",
                 chars_accepted, blank_chars, writes_checked);
        $display("small, big, medium and spare modes, edge clipping, unknown codes, far-off pen");
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #6_000_000;
        $display("[%0t] timeout, %0d requests and %0d writes outstanding", $time,
                 char_requests.size(), writes_due.size());
        $display("Verification failed");
        $finish;
    end

endmodule
